// ===== design/c2rsc_pkg.sv =====
`timescale 1ns / 1ps

package c2rsc_pkg;

   // Plane geometry.
   localparam int ROWS    = 64;
   localparam int COLUMNS = 1024;

   // Field widths.
   localparam int ROW_W = 6;   // row index
   localparam int TOP_W = 7;   // row index or the empty code ROWS
   localparam int COL_W = 10;  // column index

endpackage

// ===== design/c2rsc_if.sv =====
`timescale 1ns / 1ps

interface c2rsc_req_if;
   import c2rsc_pkg::*;

   logic             valid;
   logic             ready;
   logic [COL_W-1:0] column;
   logic [TOP_W-1:0] run_top;
   logic [ROW_W-1:0] run_bottom;
   logic             new_plane;

   modport source (output valid, column, run_top, run_bottom, new_plane, input ready);
   modport sink   (input valid, column, run_top, run_bottom, new_plane, output ready);
endinterface

interface c2rsc_rsp_if;
   import c2rsc_pkg::*;

   logic             valid;
   logic             ready;
   logic [ROW_W-1:0] span_row;
   logic [COL_W-1:0] span_first;
   logic [COL_W-1:0] span_last;
   logic             last_of_run;

   modport source (output valid, span_row, span_first, span_last, last_of_run, input ready);
   modport sink   (input valid, span_row, span_first, span_last, last_of_run, output ready);
endinterface

// ===== design/c2rsc_ram.sv =====
`timescale 1ns / 1ps

module c2rsc_ram #(
   parameter int WIDTH = 10,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/column_to_row_span_converter.sv =====
`timescale 1ns / 1ps
// Sequence: a taken column first closes the rows that leave the run, top rows before bottom
// rows; each closed row is a read of the row-start memory followed by a load of the output
// register, and a stalled output register holds the sequencer in that load. It then opens
// the rows that join the run. A new column is taken only when the sequencer is back in idle.
// Reset: synchronous; clears the sequencer and the output valid, sets the previous run to
// empty (top ROWS, bottom 0). The row-start memory is not cleared; rows are opened before read.

module column_to_row_span_converter (
   input  logic clock,
   input  logic reset,
   c2rsc_req_if.sink   req_if,
   c2rsc_rsp_if.source rsp_if
);
   import c2rsc_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE  = 4'b0001,
      S_CLOSE = 4'b0010,
      S_EMIT  = 4'b0100,
      S_OPEN  = 4'b1000
   } state_type;

   localparam logic [TOP_W-1:0] TOP_EMPTY = TOP_W'(ROWS);
   localparam logic [ROW_W-1:0] BOT_MAX   = ROW_W'(ROWS - 1);

   state_type        state_ff, state_in;
   logic [TOP_W-1:0] prev_top_ff, prev_top_in;
   logic [ROW_W-1:0] prev_bottom_ff, prev_bottom_in;
   logic [TOP_W-1:0] t1_ff, t1_in, t2_ff, t2_in;
   logic [ROW_W-1:0] b1_ff, b1_in, b2_ff, b2_in;
   logic [COL_W-1:0] col_ff, col_in, last_col_ff, last_col_in;
   logic [ROW_W-1:0] row_ff, row_in;

   logic             rsp_valid_ff, rsp_valid_in;
   logic [ROW_W-1:0] span_row_ff, span_row_in;
   logic [COL_W-1:0] span_first_ff, span_first_in;
   logic [COL_W-1:0] span_last_ff, span_last_in;
   logic             last_of_run_ff, last_of_run_in;

   logic             close_top, close_bot, open_top, open_bot;
   logic             accept, out_free;
   logic [TOP_W-1:0] top_sat;
   logic [ROW_W-1:0] bot_sat;

   logic             wr_en, rd_en;
   logic [ROW_W-1:0] wr_addr, rd_addr;
   logic [COL_W-1:0] rd_data;

   c2rsc_ram #(.WIDTH(COL_W), .DEPTH(ROWS)) u_row_start (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (col_ff),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign req_if.ready = (state_ff == S_IDLE);
   assign accept       = req_if.valid && (state_ff == S_IDLE);
   assign out_free     = !rsp_valid_ff || rsp_if.ready;

   assign top_sat = (req_if.run_top > TOP_EMPTY) ? TOP_EMPTY : req_if.run_top;
   assign bot_sat = (req_if.run_bottom > BOT_MAX) ? BOT_MAX : req_if.run_bottom;

   // Rows still to close on top and bottom, and rows still to open.
   assign close_top = (t1_ff < t2_ff) && (t1_ff <= {1'b0, b1_ff});
   assign close_bot = (b1_ff > b2_ff) && ({1'b0, b1_ff} >= t1_ff);
   assign open_top  = (t2_ff < t1_ff) && (t2_ff <= {1'b0, b2_ff});
   assign open_bot  = (b2_ff > b1_ff) && ({1'b0, b2_ff} >= t2_ff);

   always_comb begin
      state_in       = state_ff;
      prev_top_in    = prev_top_ff;
      prev_bottom_in = prev_bottom_ff;
      t1_in          = t1_ff;
      t2_in          = t2_ff;
      b1_in          = b1_ff;
      b2_in          = b2_ff;
      col_in         = col_ff;
      last_col_in    = last_col_ff;
      row_in         = row_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_if.ready;
      span_row_in    = span_row_ff;
      span_first_in  = span_first_ff;
      span_last_in   = span_last_ff;
      last_of_run_in = last_of_run_ff;
      wr_en          = 1'b0;
      wr_addr        = t2_ff[ROW_W-1:0];
      rd_en          = 1'b0;
      rd_addr        = t1_ff[ROW_W-1:0];

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               t1_in          = req_if.new_plane ? TOP_EMPTY : prev_top_ff;
               b1_in          = prev_bottom_ff;
               t2_in          = top_sat;
               b2_in          = bot_sat;
               col_in         = req_if.column;
               last_col_in    = req_if.column - COL_W'(1);
               prev_top_in    = top_sat;
               prev_bottom_in = bot_sat;
               state_in       = S_CLOSE;
            end
         end
         S_CLOSE: begin
            if (close_top) begin
               rd_en    = 1'b1;
               rd_addr  = t1_ff[ROW_W-1:0];
               row_in   = t1_ff[ROW_W-1:0];
               t1_in    = t1_ff + TOP_W'(1);
               state_in = S_EMIT;
            end else if (close_bot) begin
               rd_en    = 1'b1;
               rd_addr  = b1_ff;
               row_in   = b1_ff;
               b1_in    = b1_ff - ROW_W'(1);
               state_in = S_EMIT;
            end else begin
               state_in = S_OPEN;
            end
         end
         S_EMIT: begin
            // The read data holds until the output register has room for the beat.
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               span_row_in    = row_ff;
               span_first_in  = rd_data;
               span_last_in   = last_col_ff;
               last_of_run_in = !(close_top || close_bot);
               state_in       = (close_top || close_bot) ? S_CLOSE : S_OPEN;
            end
         end
         S_OPEN: begin
            if (open_top) begin
               wr_en   = 1'b1;
               wr_addr = t2_ff[ROW_W-1:0];
               t2_in   = t2_ff + TOP_W'(1);
            end else if (open_bot) begin
               wr_en   = 1'b1;
               wr_addr = b2_ff;
               b2_in   = b2_ff - ROW_W'(1);
            end else begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         prev_top_ff    <= TOP_EMPTY;
         prev_bottom_ff <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         prev_top_ff    <= prev_top_in;
         prev_bottom_ff <= prev_bottom_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      t1_ff          <= t1_in;
      t2_ff          <= t2_in;
      b1_ff          <= b1_in;
      b2_ff          <= b2_in;
      col_ff         <= col_in;
      last_col_ff    <= last_col_in;
      row_ff         <= row_in;
      span_row_ff    <= span_row_in;
      span_first_ff  <= span_first_in;
      span_last_ff   <= span_last_in;
      last_of_run_ff <= last_of_run_in;
   end

   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.span_row    = span_row_ff;
   assign rsp_if.span_first  = span_first_ff;
   assign rsp_if.span_last   = span_last_ff;
   assign rsp_if.last_of_run = last_of_run_ff;

endmodule

// ===== design/c2rsc_checker.sv =====
`timescale 1ns / 1ps

module c2rsc_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_ready,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic [c2rsc_pkg::ROW_W-1:0] span_row,
   input logic [c2rsc_pkg::COL_W-1:0] span_first,
   input logic [c2rsc_pkg::COL_W-1:0] span_last,
   input logic                       last_of_run
);
   import c2rsc_pkg::*;

   // A stalled beat stays offered.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp valid dropped while stalled");

   // A stalled beat keeps its payload.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(span_row) && $stable(span_first)
                                  && $stable(span_last) && $stable(last_of_run))
      else $error("rsp payload changed while stalled");

   // A taken column keeps the block busy for at least the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("req ready high right after a column was taken");

   // Reset leaves the block idle with no beat pending.
   assert property (@(posedge clock)
      reset |=> req_ready && !rsp_valid)
      else $error("block not idle after reset");

endmodule

bind column_to_row_span_converter c2rsc_checker u_c2rsc_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_if.valid),
   .req_ready   (req_if.ready),
   .rsp_valid   (rsp_if.valid),
   .rsp_ready   (rsp_if.ready),
   .span_row    (rsp_if.span_row),
   .span_first  (rsp_if.span_first),
   .span_last   (rsp_if.span_last),
   .last_of_run (rsp_if.last_of_run)
);

// ===== tb/sv/span_checker.sv =====
`timescale 1ns / 1ps

module span_checker (
   input  logic clock,
   input  logic reset,
   c2rsc_req_if req_mon,
   c2rsc_rsp_if rsp_mon,
   output int   mismatches,
   output int   spans_owed
);
   import c2rsc_pkg::*;

   typedef struct {
      logic [ROW_W-1:0] row;
      logic [COL_W-1:0] first;
      logic [COL_W-1:0] last;
      logic             tail;
   } span_type;

   span_type         pending_spans[$];
   logic [COL_W-1:0] row_opened_at[ROWS];
   logic [TOP_W-1:0] cover_top;
   logic [ROW_W-1:0] cover_bottom;

   initial begin
      mismatches = 0;
      spans_owed = 0;
   end

   task automatic report(input string msg);
      $display("[%0t] span check: %s", $time, msg);
      mismatches++;
   endtask

   // Closes the rows that leave the run (top ascending, then bottom descending),
   // then records this column as the start of every newly covered row.
   task automatic close_and_open(input logic [COL_W-1:0] col, input logic [TOP_W-1:0] top,
                                 input logic [ROW_W-1:0] bottom, input logic fresh);
      int               t_new;
      int               b_new;
      int               t_old;
      int               b_old;
      int               t_sat;
      int               b_sat;
      int               closing[$];
      logic [COL_W-1:0] end_col;
      span_type         s;
      end_col = col - 1'b1;
      t_sat = (top > ROWS) ? ROWS : int'(top);
      b_sat = (bottom > ROWS - 1) ? ROWS - 1 : int'(bottom);
      t_new = t_sat;
      b_new = b_sat;
      t_old = fresh ? ROWS : int'(cover_top);
      b_old = int'(cover_bottom);
      while (t_old < t_new && t_old <= b_old) begin
         closing.push_back(t_old);
         t_old++;
      end
      while (b_old > b_new && b_old >= t_old) begin
         closing.push_back(b_old);
         b_old--;
      end
      foreach (closing[i]) begin
         s.row   = ROW_W'(closing[i]);
         s.first = row_opened_at[closing[i]];
         s.last  = end_col;
         s.tail  = (i == closing.size() - 1);
         pending_spans.push_back(s);
      end
      while (t_new < t_old && t_new <= b_new) begin
         row_opened_at[t_new] = col;
         t_new++;
      end
      while (b_new > b_old && b_new >= t_new) begin
         row_opened_at[b_new] = col;
         b_new--;
      end
      cover_top    = TOP_W'(t_sat);
      cover_bottom = ROW_W'(b_sat);
   endtask

   always @(posedge clock) begin
      span_type want;
      if (reset) begin
         pending_spans.delete();
         cover_top    = TOP_W'(ROWS);
         cover_bottom = '0;
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (pending_spans.size() == 0) begin
               report($sformatf("unexpected beat row %0d first %0d last %0d",
                                rsp_mon.span_row, rsp_mon.span_first, rsp_mon.span_last));
            end else begin
               want = pending_spans.pop_front();
               if (rsp_mon.span_row !== want.row)
                  report($sformatf("span_row %0d, expected %0d", rsp_mon.span_row, want.row));
               if (rsp_mon.span_first !== want.first)
                  report($sformatf("span_first %0d, expected %0d (row %0d)",
                                   rsp_mon.span_first, want.first, want.row));
               if (rsp_mon.span_last !== want.last)
                  report($sformatf("span_last %0d, expected %0d (row %0d)",
                                   rsp_mon.span_last, want.last, want.row));
               if (rsp_mon.last_of_run !== want.tail)
                  report($sformatf("last_of_run %0b, expected %0b (row %0d)",
                                   rsp_mon.last_of_run, want.tail, want.row));
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            close_and_open(req_mon.column, req_mon.run_top,
                           req_mon.run_bottom, req_mon.new_plane);
         end
      end
      spans_owed = pending_spans.size();
   end

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
   import c2rsc_pkg::*;

   localparam int CYCLE_LIMIT   = 4_000_000;
   localparam int COLUMN_TARGET = 430;

   logic clock = 1'b0;
   logic reset;
   int   cycles = 0;
   int   mismatches;
   int   spans_owed;
   int   columns_sent = 0;
   bit   calm = 1'b0;
   bit   drained_mid = 1'b0;

   c2rsc_req_if req_if ();
   c2rsc_rsp_if rsp_if ();

   column_to_row_span_converter i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   span_checker i_checker (
      .clock      (clock),
      .reset      (reset),
      .req_mon    (req_if),
      .rsp_mon    (rsp_if),
      .mismatches (mismatches),
      .spans_owed (spans_owed)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // Mostly back-to-back, often a short pause, now and then a long one.
   function automatic int idle_len();
      int r;
      if (calm) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Result side: ready may drop for a random stretch after each accepted beat.
   initial begin
      int gap;
      rsp_if.ready = 1'b0;
      @(negedge clock);
      forever begin
         gap = idle_len();
         if (gap > 0) begin
            rsp_if.ready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_if.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_if.valid && rsp_if.ready));
         @(negedge clock);
      end
   end

   task automatic feed_column(input int col, input int top, input int bottom, input bit fresh);
      int gap;
      gap = idle_len();
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_if.column     <= COL_W'(col);
      req_if.run_top    <= TOP_W'(top);
      req_if.run_bottom <= ROW_W'(bottom);
      req_if.new_plane  <= fresh;
      req_if.valid      <= 1'b1;
      do @(posedge clock); while (!(req_if.valid && req_if.ready));
      @(negedge clock);
      columns_sent++;
   endtask

   task automatic wait_for_spans();
      req_if.valid <= 1'b0;
      do @(negedge clock); while (spans_owed != 0);
   endtask

   // A plane of consecutive columns whose run drifts a few rows per column,
   // with the odd empty column and the odd jump.
   task automatic run_plane(input bit fresh);
      int col;
      int top;
      int bottom;
      int len;
      col    = $urandom_range(0, COLUMNS - 1);
      len    = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(2, 12);
      top    = $urandom_range(0, ROWS - 1);
      bottom = $urandom_range(top, ROWS - 1);
      for (int k = 0; k < len; k++) begin
         if ($urandom_range(0, 11) == 0)
            feed_column(col, ROWS, $urandom_range(0, ROWS - 1), fresh && k == 0);
         else
            feed_column(col, top, bottom, fresh && k == 0);
         col = (col + 1) % COLUMNS;
         if ($urandom_range(0, 7) == 0) begin
            top    = $urandom_range(0, ROWS - 1);
            bottom = $urandom_range(0, ROWS - 1);
         end else begin
            top    += int'($urandom_range(0, 6)) - 3;
            bottom += int'($urandom_range(0, 6)) - 3;
         end
         if (top < 0) top = 0;
         if (top > ROWS - 1) top = ROWS - 1;
         if (bottom < 0) bottom = 0;
         if (bottom > ROWS - 1) bottom = ROWS - 1;
      end
   endtask

   initial begin
      reset                = 1'b1;
      req_if.valid         = 1'b0;
      req_if.column        = '0;
      req_if.run_top       = '0;
      req_if.run_bottom    = '0;
      req_if.new_plane     = 1'b0;
      repeat (9) @(negedge clock);
      reset <= 1'b0;

      feed_column(0, ROWS, 0, 1'b1);
      feed_column(1, 0, 63, 1'b0);
      feed_column(2, 0, 63, 1'b0);
      feed_column(3, 10, 50, 1'b0);
      // Top above the empty code counts as empty and closes every open row.
      feed_column(4, 127, 0, 1'b0);
      feed_column(5, 20, 30, 1'b0);
      // Top below bottom covers nothing.
      feed_column(6, 40, 10, 1'b0);
      feed_column(7, 5, 60, 1'b0);
      feed_column(8, 5, 60, 1'b1);
      // At column zero the span ends on the last screen column.
      feed_column(0, 6, 59, 1'b0);
      feed_column(1023, ROWS, 63, 1'b0);
      feed_column(512, 65, 63, 1'b1);
      feed_column(600, 0, 0, 1'b0);
      feed_column(601, 63, 63, 1'b0);
      feed_column(602, 0, 63, 1'b0);
      feed_column(700, 32, 31, 1'b0);
      feed_column(701, 96, 5, 1'b0);
      feed_column(702, 30, 40, 1'b0);
      feed_column(703, 35, 45, 1'b0);
      feed_column(704, 25, 38, 1'b0);
      feed_column(705, ROWS, 0, 1'b1);
      wait_for_spans();

      while (columns_sent < COLUMN_TARGET) begin
         if (columns_sent >= 250 && !drained_mid) begin
            wait_for_spans();
            drained_mid = 1'b1;
         end
         calm = ($urandom_range(0, 4) == 0);
         if ($urandom_range(0, 6) == 0) begin
            repeat ($urandom_range(1, 4))
               feed_column($urandom_range(0, COLUMNS - 1), $urandom_range(0, 127),
                           $urandom_range(0, ROWS - 1), $urandom_range(0, 1));
         end else begin
            run_plane($urandom_range(0, 4) != 0);
         end
      end
      calm = 1'b0;
      req_if.valid <= 1'b0;

      while (spans_owed != 0) @(negedge clock);
      repeat (200) @(negedge clock);
      if (mismatches == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
